@@ hdl/lts_pkg.sv @@
// Shared types and constants for the locality traffic split block.
package lts_pkg;

    localparam int MAX_LOCALITIES_DEF = 16;
    localparam int MAX_HOSTS_DEF      = 1023;

    localparam int UTIL_SUM_W  = 26;
    localparam int HOSTS_W     = 10;
    localparam int UTIL_W      = 16;
    localparam int SHARE_W     = 14;
    localparam int INDEX_W     = 4;
    localparam int TOTAL_W     = 5;
    localparam int ALPHA_W     = 17;
    localparam int PCT_W       = 7;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 17;

    localparam logic [CFG_INDEX_W-1:0] REG_EMA_ALPHA  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_VAR_THRESH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PROBE_PCT  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_LOCAL  = 2'd3;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET  = 17'd32768;
    localparam logic [UTIL_W-1:0]  THRESH_RESET = 16'd3277;
    localparam logic [SHARE_W-1:0] FULL_SHARE   = 14'd10000;
    localparam int                 UTIL_ONE     = 32768;

    typedef struct packed {
        logic [UTIL_SUM_W-1:0] utilization_sum;
        logic [HOSTS_W-1:0]    valid_hosts;
        logic                  local_present;
        logic                  last_locality;
    } lts_in_t;

    typedef struct packed {
        logic               active;
        logic [SHARE_W-1:0] local_share;
        logic [INDEX_W-1:0] locality_index;
        logic [SHARE_W-1:0] cumulative_capacity;
        logic [TOTAL_W-1:0] locality_total;
        logic               run_end;
    } lts_out_t;

    typedef struct packed {
        logic [ALPHA_W-1:0] smooth_weight;
        logic [UTIL_W-1:0]  variance_threshold;
        logic [PCT_W-1:0]   probe_percent;
        logic [PCT_W-1:0]   local_floor_pct;
    } lts_cfg_t;

endpackage

@@ hdl/lts_stream_if.sv @@
// Valid/ready channel interfaces for items and configuration writes.
interface lts_in_if;
    logic valid;
    logic ready;
    lts_pkg::lts_in_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lts_out_if;
    logic valid;
    logic ready;
    lts_pkg::lts_out_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lts_cfg_if;
    logic valid;
    logic ready;
    logic [lts_pkg::CFG_INDEX_W-1:0] index;
    logic [lts_pkg::CFG_DATA_W-1:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/lts_divider.sv @@
// Restoring serial divider, one quotient bit per cycle.
module lts_divider #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 48
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numerator,
    input  logic [DEN_W-1:0] denominator,
    output logic             busy,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W:0]   rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[DEN_W-1:0], quo_reg[NUM_W-1]};
        if (start)
        begin
            quo_next  = numerator;
            rem_next  = '0;
            den_next  = denominator;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

@@ hdl/lts_front.sv @@
// Front end: accepts locality items, computes each raw average and holds it for the back end.
module lts_front #(
    parameter int MAX_LOC = lts_pkg::MAX_LOCALITIES_DEF,
    parameter int MAX_HOST = lts_pkg::MAX_HOSTS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    lts_in_if.sink in_ch,
    output logic                     q_valid,
    input  logic                     q_ready,
    output logic [lts_pkg::UTIL_W-1:0]  q_raw,
    output logic [lts_pkg::HOSTS_W-1:0] q_hosts,
    output logic                     q_local,
    output logic                     q_last,
    output logic                     q_keep
);
    import lts_pkg::*;
    localparam int POS_W = $clog2(MAX_LOC + 1);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_OUT  = 3'b100
    } fstate_t;

    fstate_t            st_reg, st_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [HOSTS_W-1:0] vh_reg, vh_next, vh_in;
    logic               lp_reg, lp_next;
    logic               last_reg, last_next;
    logic               keep_reg, keep_next;
    logic [UTIL_W-1:0]  raw_reg, raw_next;
    logic               div_start, div_busy, div_done;
    logic [27:0]        div_q;
    logic [27:0]        num;

    always_comb
    begin
        vh_in = in_ch.data.valid_hosts;
        if (32'(vh_in) > MAX_HOST)
        begin
            vh_in = HOSTS_W'(MAX_HOST);
        end
    end

    assign num = 28'(in_ch.data.utilization_sum) + 28'(vh_in >> 1);

    lts_divider #(.NUM_W(28), .DEN_W(HOSTS_W)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .numerator(num),
        .denominator(vh_in), .busy(div_busy), .done(div_done), .quotient(div_q)
    );

    assign in_ch.ready = (st_reg == F_IDLE);

    always_comb
    begin
        st_next   = st_reg;
        pos_next  = pos_reg;
        vh_next   = vh_reg;
        lp_next   = lp_reg;
        last_next = last_reg;
        keep_next = keep_reg;
        raw_next  = raw_reg;
        div_start = 1'b0;
        unique case (st_reg)
            F_IDLE:
            begin
                if (in_ch.valid)
                begin
                    vh_next   = vh_in;
                    lp_next   = in_ch.data.local_present;
                    last_next = in_ch.data.last_locality;
                    keep_next = (32'(pos_reg) < MAX_LOC);
                    raw_next  = '0;
                    if (in_ch.data.last_locality)
                    begin
                        pos_next = '0;
                    end
                    else if (32'(pos_reg) < MAX_LOC)
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                    if (vh_in != '0 && 32'(pos_reg) < MAX_LOC)
                    begin
                        div_start = 1'b1;
                        st_next   = F_DIV;
                    end
                    else
                    begin
                        st_next = F_OUT;
                    end
                end
            end
            F_DIV:
            begin
                if (div_done)
                begin
                    raw_next = (div_q > 28'd65535) ? 16'hFFFF : div_q[UTIL_W-1:0];
                    st_next  = F_OUT;
                end
            end
            F_OUT:
            begin
                if (q_ready)
                begin
                    st_next = F_IDLE;
                end
            end
            default:
            begin
                st_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= F_IDLE;
            pos_reg <= '0;
        end
        else
        begin
            st_reg  <= st_next;
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vh_reg   <= vh_next;
        lp_reg   <= lp_next;
        last_reg <= last_next;
        keep_reg <= keep_next;
        raw_reg  <= raw_next;
    end

    assign q_valid = (st_reg == F_OUT) && !div_busy;
    assign q_raw   = raw_reg;
    assign q_hosts = vh_reg;
    assign q_local = lp_reg;
    assign q_last  = last_reg;
    assign q_keep  = keep_reg;
endmodule

@@ hdl/lts_back.sv @@
// Back end: smoothing, global average, split decision and result emission.
module lts_back #(
    parameter int MAX_LOC = lts_pkg::MAX_LOCALITIES_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  lts_pkg::lts_cfg_t           cfg,
    input  logic                        q_valid,
    output logic                        q_ready,
    input  logic [lts_pkg::UTIL_W-1:0]  q_raw,
    input  logic [lts_pkg::HOSTS_W-1:0] q_hosts,
    input  logic                        q_local,
    input  logic                        q_last,
    input  logic                        q_keep,
    lts_out_if.source out_ch
);
    import lts_pkg::*;
    localparam int IDX_W = $clog2(MAX_LOC);
    localparam int CNT_W = $clog2(MAX_LOC + 1);
    localparam int HT_W  = HOSTS_W + CNT_W;
    localparam int W_W   = UTIL_W + HT_W;
    localparam int DIV_W = 48;

    typedef enum logic [12:0] {
        B_COLLECT = 13'b0000000000001,
        B_CLEAR   = 13'b0000000000010,
        B_EMA     = 13'b0000000000100,
        B_EMA_WR  = 13'b0000000001000,
        B_SUM     = 13'b0000000010000,
        B_DEV     = 13'b0000000100000,
        B_SPDIV   = 13'b0000001000000,
        B_PCT     = 13'b0000010000000,
        B_HEAD    = 13'b0000100000000,
        B_CAP     = 13'b0001000000000,
        B_CAPW    = 13'b0010000000000,
        B_CMP     = 13'b0100000000000,
        B_EMIT    = 13'b1000000000000
    } bstate_t;

    bstate_t st_reg, st_next;

    logic [UTIL_W-1:0]  smooth_reg [MAX_LOC];
    logic [UTIL_W-1:0]  smooth_next [MAX_LOC];
    logic [HOSTS_W-1:0] hosts_reg [MAX_LOC];
    logic [HOSTS_W-1:0] hosts_next [MAX_LOC];
    logic [UTIL_W-1:0]  raw_mem [MAX_LOC];
    logic [SHARE_W-1:0] cap_reg [MAX_LOC];
    logic [SHARE_W-1:0] cap_next [MAX_LOC];
    logic [SHARE_W-1:0] ncap_reg [MAX_LOC];
    logic [SHARE_W-1:0] ncap_next [MAX_LOC];

    logic [CNT_W-1:0]   pos_reg, pos_next;
    logic               lflag_reg, lflag_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [CNT_W-1:0]   known_reg, known_next;
    logic               first_reg, first_next;
    logic               on_reg, on_next;
    logic [SHARE_W-1:0] slocal_reg, slocal_next;
    logic [CNT_W-1:0]   scount_reg, scount_next;
    logic [CNT_W-1:0]   i_reg, i_next;
    logic [CNT_W-1:0]   lo_reg, lo_next;
    logic [UTIL_W-1:0]  raw_rd_reg;
    logic [33:0]        prod_a_reg, prod_a_next;
    logic [33:0]        prod_b_reg, prod_b_next;
    logic [HT_W-1:0]    th_reg, th_next;
    logic [W_W-1:0]     tw_reg, tw_next;
    logic [W_W:0]       dev_reg, dev_next;
    logic [W_W-1:0]     thr_reg, thr_next;
    logic               spill_reg, spill_next;
    logic [PCT_W-1:0]   pct_reg, pct_next;
    logic [20:0]        head_reg, head_next;
    logic [20:0]        cum_reg, cum_next;
    logic               chg_reg, chg_next;

    logic               ov_reg, ov_next;
    lts_out_t           od_reg, od_next;

    logic               div_start;
    logic [DIV_W-1:0]   div_num, div_q;
    logic [DIV_W-1:0]   div_den;
    logic               div_busy, div_done;

    logic [ALPHA_W-1:0] alpha;
    logic [PCT_W-1:0]   probe, minl;
    logic [IDX_W-1:0]   ii;
    logic [UTIL_W-1:0]  hr;
    logic [33:0]        acc;
    logic [W_W:0]       local_w;
    logic [PCT_W-1:0]   sp;
    logic [PCT_W-1:0]   lp;
    logic               raw_we;

    lts_divider #(.NUM_W(DIV_W), .DEN_W(DIV_W)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .numerator(div_num),
        .denominator(div_den), .busy(div_busy), .done(div_done), .quotient(div_q)
    );

    assign alpha = (cfg.smooth_weight > 17'd65536) ? 17'd65536 : cfg.smooth_weight;
    assign probe = (cfg.probe_percent > 7'd100) ? 7'd100 : cfg.probe_percent;
    assign minl  = (cfg.local_floor_pct > 7'd100) ? 7'd100 : cfg.local_floor_pct;
    assign ii    = i_reg[IDX_W-1:0];
    assign hr    = (smooth_reg[ii] < 16'(UTIL_ONE)) ? 16'(UTIL_ONE) - smooth_reg[ii] : '0;
    assign acc   = prod_a_reg + prod_b_reg + 34'd32768;
    assign local_w = (W_W+1)'(smooth_reg[0]) * (W_W+1)'(th_reg);
    assign raw_we  = q_ready && q_valid && q_keep;

    assign q_ready = (st_reg == B_COLLECT) && !ov_reg;
    assign out_ch.valid = ov_reg;
    assign out_ch.data  = od_reg;

    always_ff @(posedge clk)
    begin
        if (raw_we)
        begin
            raw_mem[pos_reg[IDX_W-1:0]] <= q_raw;
        end
        raw_rd_reg <= raw_mem[i_next[IDX_W-1:0]];
    end

    always_comb
    begin
        st_next     = st_reg;
        smooth_next = smooth_reg;
        hosts_next  = hosts_reg;
        cap_next    = cap_reg;
        ncap_next   = ncap_reg;
        pos_next    = pos_reg;
        lflag_next  = lflag_reg;
        n_next      = n_reg;
        known_next  = known_reg;
        first_next  = first_reg;
        on_next     = on_reg;
        slocal_next = slocal_reg;
        scount_next = scount_reg;
        i_next      = i_reg;
        lo_next     = lo_reg;
        prod_a_next = prod_a_reg;
        prod_b_next = prod_b_reg;
        th_next     = th_reg;
        tw_next     = tw_reg;
        dev_next    = dev_reg;
        thr_next    = thr_reg;
        spill_next  = spill_reg;
        pct_next    = pct_reg;
        head_next   = head_reg;
        cum_next    = cum_reg;
        chg_next    = chg_reg;
        ov_next     = ov_reg;
        od_next     = od_reg;
        div_start   = 1'b0;
        div_num     = '0;
        div_den     = '0;
        sp          = '0;
        lp          = '0;
        if (ov_reg && out_ch.ready)
        begin
            ov_next = 1'b0;
        end
        unique case (st_reg)
            B_COLLECT:
            begin
                if (q_valid && !ov_reg)
                begin
                    if (pos_reg == '0)
                    begin
                        lflag_next = q_local;
                    end
                    if (q_keep)
                    begin
                        hosts_next[pos_reg[IDX_W-1:0]] = q_hosts;
                        pos_next = pos_reg + 1'b1;
                    end
                    if (q_last)
                    begin
                        n_next   = q_keep ? pos_reg + 1'b1 : pos_reg;
                        pos_next = '0;
                        if (n_next < CNT_W'(2) || !((pos_reg == '0) ? q_local : lflag_reg))
                        begin
                            if (on_reg)
                            begin
                                on_next     = 1'b0;
                                slocal_next = FULL_SHARE;
                                for (int k = 0; k < MAX_LOC; k++)
                                begin
                                    cap_next[k] = '0;
                                end
                                scount_next = n_next;
                                ov_next = 1'b1;
                                od_next.active              = 1'b0;
                                od_next.local_share         = FULL_SHARE;
                                od_next.locality_index      = '0;
                                od_next.cumulative_capacity = '0;
                                od_next.locality_total      = TOTAL_W'(n_next);
                                od_next.run_end             = 1'b1;
                            end
                        end
                        else
                        begin
                            if (n_next != known_reg)
                            begin
                                lo_next    = (known_reg < n_next) ? known_reg : n_next;
                                known_next = n_next;
                                first_next = 1'b1;
                            end
                            else
                            begin
                                lo_next = CNT_W'(MAX_LOC);
                            end
                            i_next  = '0;
                            st_next = B_CLEAR;
                        end
                    end
                end
            end
            B_CLEAR:
            begin
                for (int k = 0; k < MAX_LOC; k++)
                begin
                    if (CNT_W'(k) >= lo_reg)
                    begin
                        smooth_next[k] = '0;
                    end
                end
                i_next  = '0;
                st_next = B_EMA;
            end
            B_EMA:
            begin
                prod_a_next = 34'(alpha) * 34'(raw_rd_reg);
                prod_b_next = 34'(17'd65536 - alpha) * 34'(smooth_reg[ii]);
                st_next     = B_EMA_WR;
            end
            B_EMA_WR:
            begin
                if (hosts_reg[ii] != '0)
                begin
                    if (first_reg)
                    begin
                        smooth_next[ii] = raw_rd_reg;
                    end
                    else
                    begin
                        smooth_next[ii] = (acc[33:16] > 18'd65535) ? 16'hFFFF : acc[31:16];
                    end
                end
                if (i_reg + 1'b1 == n_reg)
                begin
                    first_next = 1'b0;
                    i_next     = '0;
                    th_next    = '0;
                    tw_next    = '0;
                    st_next    = B_SUM;
                end
                else
                begin
                    i_next  = i_reg + 1'b1;
                    st_next = B_EMA;
                end
            end
            B_SUM:
            begin
                th_next = th_reg + HT_W'(hosts_reg[ii]);
                tw_next = tw_reg + W_W'(26'(smooth_reg[ii]) * 26'(hosts_reg[ii]));
                if (i_reg + 1'b1 == n_reg)
                begin
                    st_next = B_DEV;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            B_DEV:
            begin
                if (th_reg == '0)
                begin
                    st_next = B_COLLECT;
                end
                else
                begin
                    dev_next = local_w - (W_W+1)'(tw_reg);
                    thr_next = W_W'(cfg.variance_threshold) * W_W'(th_reg);
                    st_next  = B_SPDIV;
                end
            end
            B_SPDIV:
            begin
                if (!dev_reg[W_W] && dev_reg != '0 && dev_reg[W_W-1:0] > thr_reg)
                begin
                    spill_next = 1'b1;
                    div_start  = 1'b1;
                    div_num    = DIV_W'(dev_reg[W_W-1:0]) * DIV_W'(100);
                    div_den    = DIV_W'(th_reg) << 15;
                end
                else
                begin
                    spill_next = 1'b0;
                end
                st_next = B_PCT;
            end
            B_PCT:
            begin
                if (!spill_reg || div_done)
                begin
                    if (spill_reg)
                    begin
                        sp = (div_q > DIV_W'(100 - minl)) ? 7'd100 - minl : div_q[PCT_W-1:0];
                        if (sp < probe)
                        begin
                            sp = probe;
                        end
                        lp = 7'd100 - sp;
                    end
                    else
                    begin
                        lp = 7'd100 - probe;
                    end
                    if (lp < minl)
                    begin
                        lp = minl;
                    end
                    if (lp > 7'd100 - probe)
                    begin
                        lp = 7'd100 - probe;
                    end
                    pct_next  = lp;
                    head_next = '0;
                    i_next    = CNT_W'(1);
                    st_next   = B_HEAD;
                end
            end
            B_HEAD:
            begin
                if (spill_reg)
                begin
                    head_next = head_reg + 21'(hr);
                end
                if (i_reg + 1'b1 >= n_reg)
                begin
                    for (int k = 0; k < MAX_LOC; k++)
                    begin
                        ncap_next[k] = '0;
                    end
                    cum_next = '0;
                    i_next   = CNT_W'(1);
                    st_next  = B_CAP;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            B_CAP:
            begin
                if (!div_busy)
                begin
                    div_start = 1'b1;
                    if (spill_reg && head_reg != '0)
                    begin
                        div_num = DIV_W'(hr) * DIV_W'(10000);
                        div_den = DIV_W'(head_reg);
                    end
                    else
                    begin
                        div_num = DIV_W'(10000);
                        div_den = DIV_W'(n_reg - 1'b1);
                    end
                    st_next = B_CAPW;
                end
            end
            B_CAPW:
            begin
                if (div_done)
                begin
                    cum_next      = cum_reg + div_q[20:0];
                    ncap_next[ii] = cum_next[SHARE_W-1:0];
                    if (i_reg + 1'b1 >= n_reg)
                    begin
                        st_next = B_CMP;
                    end
                    else
                    begin
                        i_next  = i_reg + 1'b1;
                        st_next = B_CAP;
                    end
                end
            end
            B_CMP:
            begin
                chg_next = !on_reg || scount_reg != n_reg
                           || slocal_reg != SHARE_W'(pct_reg) * SHARE_W'(100);
                for (int k = 0; k < MAX_LOC; k++)
                begin
                    if (ncap_reg[k] != cap_reg[k])
                    begin
                        chg_next = 1'b1;
                    end
                end
                if (chg_next)
                begin
                    on_next     = 1'b1;
                    scount_next = n_reg;
                    slocal_next = SHARE_W'(pct_reg) * SHARE_W'(100);
                    cap_next    = ncap_reg;
                    i_next      = '0;
                    st_next     = B_EMIT;
                end
                else
                begin
                    st_next = B_COLLECT;
                end
            end
            B_EMIT:
            begin
                if (!ov_reg || out_ch.ready)
                begin
                    ov_next = 1'b1;
                    od_next.active              = 1'b1;
                    od_next.local_share         = slocal_reg;
                    od_next.locality_index      = INDEX_W'(i_reg);
                    od_next.cumulative_capacity = cap_reg[ii];
                    od_next.locality_total      = TOTAL_W'(n_reg);
                    od_next.run_end             = (i_reg + 1'b1 == n_reg);
                    if (i_reg + 1'b1 == n_reg)
                    begin
                        st_next = B_COLLECT;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                st_next = B_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= B_COLLECT;
            for (int k = 0; k < MAX_LOC; k++)
            begin
                smooth_reg[k] <= '0;
                hosts_reg[k]  <= '0;
                cap_reg[k]    <= '0;
            end
            pos_reg    <= '0;
            lflag_reg  <= 1'b0;
            known_reg  <= '0;
            first_reg  <= 1'b1;
            on_reg     <= 1'b0;
            slocal_reg <= FULL_SHARE;
            scount_reg <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            st_reg     <= st_next;
            smooth_reg <= smooth_next;
            hosts_reg  <= hosts_next;
            cap_reg    <= cap_next;
            pos_reg    <= pos_next;
            lflag_reg  <= lflag_next;
            known_reg  <= known_next;
            first_reg  <= first_next;
            on_reg     <= on_next;
            slocal_reg <= slocal_next;
            scount_reg <= scount_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ncap_reg   <= ncap_next;
        n_reg      <= n_next;
        i_reg      <= i_next;
        lo_reg     <= lo_next;
        prod_a_reg <= prod_a_next;
        prod_b_reg <= prod_b_next;
        th_reg     <= th_next;
        tw_reg     <= tw_next;
        dev_reg    <= dev_next;
        thr_reg    <= thr_next;
        spill_reg  <= spill_next;
        pct_reg    <= pct_next;
        head_reg   <= head_next;
        cum_reg    <= cum_next;
        chg_reg    <= chg_next;
        od_reg     <= od_next;
    end
endmodule

@@ hdl/locality_traffic_split_core.sv @@
// Top level of the locality traffic split block.
// An item passes through the front end, where a serial divider forms the
// locality's rounded raw average one bit per cycle; the closing item of an update
// then occupies the back end for the EMA step, the sum and headroom passes, and
// one 48-step serial division for the spill percent (only when the local share
// spills) and for each capacity entry after the first, before results leave one
// per cycle while the output channel is ready.
module locality_traffic_split_core #(
    parameter int MAX_LOCALITIES = lts_pkg::MAX_LOCALITIES_DEF,
    parameter int MAX_HOSTS      = lts_pkg::MAX_HOSTS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    lts_cfg_if.sink    cfg,
    lts_in_if.sink     in_item,
    lts_out_if.source  out_item
);
    import lts_pkg::*;

    lts_cfg_t           cfg_reg;
    logic               q_valid, q_ready, q_local, q_last, q_keep;
    logic [UTIL_W-1:0]  q_raw;
    logic [HOSTS_W-1:0] q_hosts;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.smooth_weight      <= ALPHA_RESET;
            cfg_reg.variance_threshold <= THRESH_RESET;
            cfg_reg.probe_percent      <= '0;
            cfg_reg.local_floor_pct    <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_EMA_ALPHA:  cfg_reg.smooth_weight <= cfg.data;
                REG_VAR_THRESH: cfg_reg.variance_threshold <= cfg.data[UTIL_W-1:0];
                REG_PROBE_PCT:  cfg_reg.probe_percent <= cfg.data[PCT_W-1:0];
                REG_MIN_LOCAL:  cfg_reg.local_floor_pct <= cfg.data[PCT_W-1:0];
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    lts_front #(.MAX_LOC(MAX_LOCALITIES), .MAX_HOST(MAX_HOSTS)) u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_item),
        .q_valid(q_valid), .q_ready(q_ready), .q_raw(q_raw), .q_hosts(q_hosts),
        .q_local(q_local), .q_last(q_last), .q_keep(q_keep)
    );

    lts_back #(.MAX_LOC(MAX_LOCALITIES)) u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_raw(q_raw), .q_hosts(q_hosts),
        .q_local(q_local), .q_last(q_last), .q_keep(q_keep), .out_ch(out_item)
    );
endmodule

@@ verif/tb.sv @@
// Self-checking testbench for the locality traffic split core.
`timescale 1ns / 100ps

import lts_pkg::*;

class split_scoreboard;
    bit [ALPHA_W-1:0] alpha_reg;
    bit [UTIL_W-1:0]  thresh_reg;
    bit [PCT_W-1:0]   probe_reg;
    bit [PCT_W-1:0]   minl_reg;
    bit [UTIL_W-1:0]  smooth [16];
    bit [HOSTS_W-1:0] hosts [16];
    bit [UTIL_W-1:0]  raw_avg [16];
    bit [SHARE_W-1:0] cur_cap [16];
    bit [TOTAL_W-1:0] known_n;
    bit [TOTAL_W-1:0] pos;
    bit [TOTAL_W-1:0] cur_n;
    bit               first_load;
    bit               held_local;
    bit               cur_on;
    bit [SHARE_W-1:0] cur_local;
    lts_out_t         split_q [$];
    int               errors;
    int               results_seen;

    function new();
        alpha_reg = ALPHA_RESET;
        thresh_reg = THRESH_RESET;
        probe_reg = 0;
        minl_reg = 0;
        for (int i = 0; i < 16; i++)
        begin
            smooth[i] = 0;
            hosts[i] = 0;
            raw_avg[i] = 0;
            cur_cap[i] = 0;
        end
        known_n = 0;
        pos = 0;
        cur_n = 0;
        first_load = 1;
        held_local = 0;
        cur_on = 0;
        cur_local = FULL_SHARE;
        errors = 0;
        results_seen = 0;
    endfunction

    function void write_reg(bit [CFG_INDEX_W-1:0] idx, bit [CFG_DATA_W-1:0] val);
        case (idx)
            REG_EMA_ALPHA:  alpha_reg = val;
            REG_VAR_THRESH: thresh_reg = val[UTIL_W-1:0];
            REG_PROBE_PCT:  probe_reg = val[PCT_W-1:0];
            REG_MIN_LOCAL:  minl_reg = val[PCT_W-1:0];
        endcase
    endfunction

    function void note_item(lts_in_t it);
        longint unsigned r, acc, a, tw, th, thr, sp, maxsp, hsum, cum, h;
        longint dev;
        int n;
        int unsigned probe, minl, pct;
        bit spill, chg;
        bit [SHARE_W-1:0] nc [16];
        lts_out_t o;
        if (pos == 0)
            held_local = it.local_present;
        if (pos < 16)
        begin
            r = 0;
            if (it.valid_hosts != 0)
            begin
                r = (longint'(it.utilization_sum) + it.valid_hosts / 2) / it.valid_hosts;
                if (r > 65535)
                    r = 65535;
            end
            hosts[pos] = it.valid_hosts;
            raw_avg[pos] = UTIL_W'(r);
            pos++;
        end
        if (!it.last_locality)
            return;
        n = int'(pos);
        pos = 0;
        if (n < 2 || !held_local)
        begin
            if (!cur_on)
                return;
            cur_on = 0;
            cur_local = FULL_SHARE;
            for (int i = 0; i < 16; i++)
                cur_cap[i] = 0;
            cur_n = TOTAL_W'(n);
            o.active = 1'b0;
            o.local_share = FULL_SHARE;
            o.locality_index = '0;
            o.cumulative_capacity = '0;
            o.locality_total = TOTAL_W'(n);
            o.run_end = 1'b1;
            split_q.push_back(o);
            return;
        end
        if (n != known_n)
        begin
            for (int i = (known_n < n ? known_n : n); i < 16; i++)
                smooth[i] = 0;
            known_n = TOTAL_W'(n);
            first_load = 1;
        end
        a = alpha_reg > 65536 ? 65536 : alpha_reg;
        for (int i = 0; i < n; i++)
        begin
            if (hosts[i] != 0)
            begin
                if (first_load)
                    smooth[i] = raw_avg[i];
                else
                begin
                    acc = (a * raw_avg[i] + (65536 - a) * smooth[i] + 32768) >> 16;
                    smooth[i] = acc > 65535 ? 16'hFFFF : UTIL_W'(acc);
                end
            end
        end
        first_load = 0;
        tw = 0;
        th = 0;
        for (int i = 0; i < n; i++)
        begin
            if (hosts[i] != 0)
            begin
                tw += longint'(smooth[i]) * hosts[i];
                th += hosts[i];
            end
        end
        if (th == 0)
            return;
        probe = probe_reg > 100 ? 100 : probe_reg;
        minl = minl_reg > 100 ? 100 : minl_reg;
        dev = longint'(longint'(smooth[0]) * th) - longint'(tw);
        thr = longint'(thresh_reg) * th;
        spill = 0;
        if (dev > 0 && longint'(dev) > thr)
        begin
            sp = (dev * 100) / (32768 * th);
            maxsp = 100 - minl;
            if (sp > maxsp)
                sp = maxsp;
            if (sp < probe)
                sp = probe;
            pct = 100 - 32'(sp);
            spill = 1;
        end
        else
            pct = 100 - probe;
        if (pct < minl)
            pct = minl;
        if (pct > 100 - probe)
            pct = 100 - probe;
        for (int i = 0; i < 16; i++)
            nc[i] = 0;
        hsum = 0;
        cum = 0;
        if (spill)
            for (int i = 1; i < n; i++)
                hsum += smooth[i] < 32768 ? 32768 - smooth[i] : 0;
        if (spill && hsum > 0)
        begin
            for (int i = 1; i < n; i++)
            begin
                h = smooth[i] < 32768 ? 32768 - smooth[i] : 0;
                cum += (h * 10000) / hsum;
                nc[i] = SHARE_W'(cum);
            end
        end
        else
        begin
            for (int i = 1; i < n; i++)
            begin
                cum += 10000 / (n - 1);
                nc[i] = SHARE_W'(cum);
            end
        end
        chg = !cur_on || cur_n != n || cur_local != pct * 100;
        for (int i = 0; i < 16; i++)
            if (nc[i] != cur_cap[i])
                chg = 1;
        if (!chg)
            return;
        cur_on = 1;
        cur_n = TOTAL_W'(n);
        cur_local = SHARE_W'(pct * 100);
        for (int i = 0; i < 16; i++)
            cur_cap[i] = nc[i];
        for (int i = 0; i < n; i++)
        begin
            o.active = 1'b1;
            o.local_share = cur_local;
            o.locality_index = INDEX_W'(i);
            o.cumulative_capacity = cur_cap[i];
            o.locality_total = TOTAL_W'(n);
            o.run_end = (i + 1 == n);
            split_q.push_back(o);
        end
    endfunction

    function void check_result(lts_out_t got);
        lts_out_t want;
        results_seen++;
        if (split_q.size() == 0)
        begin
            $display("%0t: unexpected result %p", $time, got);
            errors++;
            return;
        end
        want = split_q.pop_front();
        if (got.active != want.active)
            $display("%0t: active exp %0d got %0d", $time, want.active, got.active);
        if (got.local_share != want.local_share)
            $display("%0t: local_share exp %0d got %0d", $time, want.local_share,
                     got.local_share);
        if (got.locality_index != want.locality_index)
            $display("%0t: locality_index exp %0d got %0d", $time, want.locality_index,
                     got.locality_index);
        if (got.cumulative_capacity != want.cumulative_capacity)
            $display("%0t: cumulative_capacity exp %0d got %0d", $time,
                     want.cumulative_capacity, got.cumulative_capacity);
        if (got.locality_total != want.locality_total)
            $display("%0t: locality_total exp %0d got %0d", $time, want.locality_total,
                     got.locality_total);
        if (got.run_end != want.run_end)
            $display("%0t: run_end exp %0d got %0d", $time, want.run_end, got.run_end);
        if (got != want)
            errors++;
    endfunction
endclass

module tb;
    localparam int LIMIT = 2000000;
    localparam int SETTLE = 1500;
    localparam int MAX_SUM = 67042305;

    logic clk;
    logic rst_n;
    int   cycles;
    int   items_sent;
    int   updates_sent;
    int   burst_left;
    int   cfg_writes;

    lts_cfg_if cfg ();
    lts_in_if  in_item ();
    lts_out_if out_item ();

    split_scoreboard sb;

    locality_traffic_split_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_item  (in_item),
        .out_item (out_item)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("FAIL locality_traffic_split_core");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_item.valid && out_item.ready)
            sb.check_result(out_item.data);
    end

    always @(posedge clk)
    begin
        case ((cycles >> 9) % 4)
            0: out_item.ready <= 1'b1;
            1: out_item.ready <= ($urandom_range(0, 1) == 1);
            2: out_item.ready <= ((cycles % 24) < 4);
            default: out_item.ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    task automatic send_item(lts_in_t it);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0)
            begin
                in_item.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_item.valid <= 1'b1;
        in_item.data <= it;
        do
            @(posedge clk);
        while (!in_item.ready);
        sb.note_item(it);
        items_sent++;
    endtask

    task automatic wait_idle();
        in_item.valid <= 1'b0;
        while (sb.split_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(bit [CFG_INDEX_W-1:0] idx, bit [CFG_DATA_W-1:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        do
            @(posedge clk);
        while (!cfg.ready);
        sb.write_reg(idx, val);
        cfg_writes++;
    endtask

    task automatic set_config(int alpha, int thresh, int probe, int minl);
        wait_idle();
        write_reg(REG_EMA_ALPHA, CFG_DATA_W'(alpha));
        write_reg(REG_VAR_THRESH, CFG_DATA_W'(thresh));
        write_reg(REG_PROBE_PCT, CFG_DATA_W'(probe));
        write_reg(REG_MIN_LOCAL, CFG_DATA_W'(minl));
        cfg.valid <= 1'b0;
    endtask

    // Style: 0 random, 1 hot local, 2 balanced, 3 no hosts, 4 saturated sums.
    task automatic send_update(int n, bit lp, int style);
        lts_in_t it;
        longint unsigned util, hc, sum;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 9))
                0: hc = 0;
                1: hc = 1023;
                2: hc = $urandom_range(0, 1023);
                default: hc = $urandom_range(1, 40);
            endcase
            case (style)
                1: util = (i == 0) ? $urandom_range(40000, 65535) : $urandom_range(0, 34000);
                2: util = $urandom_range(15000, 17000);
                default: util = $urandom_range(0, 65535);
            endcase
            if (style == 3)
                hc = 0;
            sum = util * hc + $urandom_range(0, hc);
            if ($urandom_range(0, 11) == 0)
                sum = $urandom_range(0, MAX_SUM);
            if (style == 4)
            begin
                hc = (i == 0) ? 1 : 1023;
                sum = (i == 0) ? MAX_SUM : 0;
            end
            if (sum > MAX_SUM)
                sum = MAX_SUM;
            it.utilization_sum = UTIL_SUM_W'(sum);
            it.valid_hosts = HOSTS_W'(hc);
            it.local_present = (i == 0) ? lp : 1'($urandom_range(0, 1));
            it.last_locality = (i == n - 1);
            send_item(it);
        end
        updates_sent++;
    endtask

    initial
    begin
        int pick;
        int target;
        sb = new();
        cycles = 0;
        items_sent = 0;
        updates_sent = 0;
        burst_left = 0;
        cfg_writes = 0;
        rst_n = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        in_item.valid = 1'b0;
        in_item.data = '0;
        out_item.ready = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_update(1, 1, 1);
        send_update(3, 1, 1);
        send_update(2, 0, 0);
        send_update(3, 1, 3);
        send_update(2, 1, 4);
        send_update(16, 1, 1);

        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0: set_config(0, 0, 0, 0);
                1: set_config(65536, 65535, 100, 100);
                2: set_config(65536, 0, 0, 100);
                3: set_config(0, 65535, 100, 0);
                4: set_config(ALPHA_RESET, THRESH_RESET, 10, 30);
                default: set_config($urandom_range(0, 65536), $urandom_range(0, 8000),
                                    $urandom_range(0, 40), $urandom_range(0, 60));
            endcase
            target = items_sent + 27;
            while (items_sent < target)
            begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    send_update(1, 1, 0);
                else if (pick == 1)
                    send_update($urandom_range(2, 5), 0, 0);
                else if (pick == 2)
                    send_update($urandom_range(16, 19), 1, 1);
                else if (pick == 3)
                    send_update($urandom_range(2, 4), 1, 3);
                else if (pick < 10)
                    send_update($urandom_range(2, 6), 1, 1);
                else if (pick < 13)
                    send_update($urandom_range(2, 6), 1, 2);
                else
                    send_update($urandom_range(2, 8), 1, 0);
            end
        end

        wait_idle();
        $display("Covered %0d items in %0d updates, %0d results, %0d register writes.",
                 items_sent, updates_sent, sb.results_seen, cfg_writes);
        if (sb.errors == 0 && sb.split_q.size() == 0)
            $display("PASS locality_traffic_split_core");
        else
            $display("FAIL locality_traffic_split_core");
        $finish;
    end
endmodule
